### rtl/sapb_pkg.sv
`timescale 1ns / 1ps

package sapb_pkg;

    // Channel full scale
    localparam logic [7:0] CHAN_MAX = 8'd255;

    // x / 255 == (x * 32897) >> 23 for every x below 2^16
    localparam logic [15:0] DIV255_MUL   = 16'd32897;
    localparam int          DIV255_SHIFT = 23;

    localparam int OFFSET_W = 24;
    localparam int PIXEL_W  = 32;
    localparam int NUM_CHAN = 3;
    localparam int QUO_W    = 8;

    // Configuration register indexes
    typedef enum logic [1:0] {
        CFG_CANVAS_WIDTH  = 2'd0,
        CFG_CANVAS_HEIGHT = 2'd1,
        CFG_ROW_STRIDE    = 2'd2,
        CFG_KEEPS_ALPHA   = 2'd3
    } t_cfg_idx;

    // Word moving through the divider stages; channel 2 red, 1 green, 0 blue
    typedef struct packed {
        logic                            hit;
        logic [OFFSET_W-1:0]             offset;
        logic [7:0]                      alpha;
        logic [7:0]                      total;
        logic [NUM_CHAN-1:0][7:0]        part;
        logic [NUM_CHAN-1:0][7:0]        low;
        logic [NUM_CHAN-1:0][QUO_W-1:0]  quo;
    } t_div_word;

endpackage

### rtl/sapb_cfg_regs.sv
`timescale 1ns / 1ps

module sapb_cfg_regs #(
    parameter int COORD_BITS = 13
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [1:0]            i_cfg_idx,
    input  logic [COORD_BITS-1:0] i_cfg_data,
    output logic [COORD_BITS-1:0] o_canvas_width,
    output logic [COORD_BITS-1:0] o_canvas_height,
    output logic [COORD_BITS-1:0] o_row_stride,
    output logic                  o_canvas_keeps_alpha
);

    logic [COORD_BITS-1:0] r_width;
    logic [COORD_BITS-1:0] r_height;
    logic [COORD_BITS-1:0] r_stride;
    logic                  r_keeps;

    // Register file, one write per cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= '0;
            r_height <= '0;
            r_stride <= '0;
            r_keeps  <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (sapb_pkg::t_cfg_idx'(i_cfg_idx))
                sapb_pkg::CFG_CANVAS_WIDTH:  r_width  <= i_cfg_data;
                sapb_pkg::CFG_CANVAS_HEIGHT: r_height <= i_cfg_data;
                sapb_pkg::CFG_ROW_STRIDE:    r_stride <= i_cfg_data;
                sapb_pkg::CFG_KEEPS_ALPHA:   r_keeps  <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    assign o_canvas_width       = r_width;
    assign o_canvas_height      = r_height;
    assign o_row_stride         = r_stride;
    assign o_canvas_keeps_alpha = r_keeps;

endmodule

### rtl/sapb_weight.sv
`timescale 1ns / 1ps

// Three stages: bounds check and products, background weight and offset,
// channel numerators and divider setup.
module sapb_weight #(
    parameter int COORD_BITS = 13
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_en,
    input  logic                  i_valid,
    input  logic [15:0]           i_pos_x,
    input  logic [15:0]           i_pos_y,
    input  logic [23:0]           i_fore_colour,
    input  logic [7:0]            i_coverage,
    input  logic [31:0]           i_under_pixel,
    input  logic [COORD_BITS-1:0] i_canvas_width,
    input  logic [COORD_BITS-1:0] i_canvas_height,
    input  logic [COORD_BITS-1:0] i_row_stride,
    input  logic                  i_canvas_keeps_alpha,
    output logic                  o_valid,
    output sapb_pkg::t_div_word   o_word
);

    localparam int PROD_W = 2 * COORD_BITS;

    // ---------------- stage 1 ----------------
    logic                  r1_vld;
    logic                  r1_hit;
    logic [15:0]           r1_bw;
    logic [PROD_W-1:0]     r1_off;
    logic [COORD_BITS-1:0] r1_x;
    logic [23:0]           r1_fore;
    logic [7:0]            r1_cov;
    logic [31:0]           r1_under;

    logic                  n_hit;
    logic [15:0]           n_bw;
    logic [PROD_W-1:0]     n_off;

    // Hit: sign bit clear, below the canvas size, and a nonzero foreground alpha
    always_comb begin
        n_hit = !i_pos_x[15] && !i_pos_y[15]
             && (i_pos_x < 16'(i_canvas_width))
             && (i_pos_y < 16'(i_canvas_height))
             && (i_coverage != 8'd0);
        n_bw  = 16'(i_under_pixel[31:24]) * 16'(sapb_pkg::CHAN_MAX - i_coverage);
        n_off = PROD_W'(i_pos_y[COORD_BITS-1:0]) * PROD_W'(i_row_stride);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
        end else if (i_en) begin
            r1_vld <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_hit   <= n_hit;
            r1_bw    <= n_bw;
            r1_off   <= n_off;
            r1_x     <= i_pos_x[COORD_BITS-1:0];
            r1_fore  <= i_fore_colour;
            r1_cov   <= i_coverage;
            r1_under <= i_under_pixel;
        end
    end

    // ---------------- stage 2 ----------------
    logic                            r2_vld;
    logic                            r2_hit;
    logic [7:0]                      r2_back;
    logic [sapb_pkg::OFFSET_W-1:0]   r2_off;
    logic [23:0]                     r2_fore;
    logic [7:0]                      r2_cov;
    logic [23:0]                     r2_under;

    logic [31:0]                     n_scaled;
    logic [7:0]                      n_back;
    logic [sapb_pkg::OFFSET_W-1:0]   n_off2;

    // Background weight: A*(255-a)/255 via reciprocal, or 255-a when opaque
    always_comb begin
        n_scaled = 32'(r1_bw) * 32'(sapb_pkg::DIV255_MUL);
        n_back   = i_canvas_keeps_alpha ?
                   n_scaled[sapb_pkg::DIV255_SHIFT +: 8] :
                   (sapb_pkg::CHAN_MAX - r1_cov);
        n_off2   = sapb_pkg::OFFSET_W'(r1_off) + sapb_pkg::OFFSET_W'(r1_x);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_vld <= 1'b0;
        end else if (i_en) begin
            r2_vld <= r1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r2_hit   <= r1_hit;
            r2_back  <= n_back;
            r2_off   <= n_off2;
            r2_fore  <= r1_fore;
            r2_cov   <= r1_cov;
            r2_under <= r1_under[23:0];
        end
    end

    // ---------------- stage 3 ----------------
    logic                 r3_vld;
    sapb_pkg::t_div_word  r3_word;
    sapb_pkg::t_div_word  n_word;
    logic [7:0]           n_total;
    logic [15:0]          n_num;

    // Total weight and per-channel numerators; numerator high byte seeds
    // the partial remainder (always below total since quotient fits 8 bits)
    always_comb begin
        n_total = r2_cov + r2_back;
        n_word  = '0;
        n_word.hit    = r2_hit;
        n_word.offset = r2_hit ? r2_off : '0;
        n_word.alpha  = i_canvas_keeps_alpha ? n_total : sapb_pkg::CHAN_MAX;
        n_word.total  = n_total;
        n_num         = '0;
        for (int c = 0; c < sapb_pkg::NUM_CHAN; c++) begin
            n_num = 16'(16'(r2_fore[8*c +: 8]) * 16'(r2_cov))
                  + 16'(16'(r2_under[8*c +: 8]) * 16'(r2_back));
            n_word.part[c] = n_num[15:8];
            n_word.low[c]  = n_num[7:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_vld <= 1'b0;
        end else if (i_en) begin
            r3_vld <= r2_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r3_word <= n_word;
        end
    end

    assign o_valid = r3_vld;
    assign o_word  = r3_word;

endmodule

### rtl/sapb_div_step.sv
`timescale 1ns / 1ps

// One restoring-division step for all channels: shift in the next numerator
// bit, subtract the total weight if it fits, shift in one quotient bit.
module sapb_div_step (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  logic                i_valid,
    input  sapb_pkg::t_div_word i_word,
    output logic                o_valid,
    output sapb_pkg::t_div_word o_word
);

    logic                r_vld;
    sapb_pkg::t_div_word r_word;
    sapb_pkg::t_div_word n_word;
    logic [8:0]          n_trial;
    logic                n_ge;

    always_comb begin
        n_word  = i_word;
        n_trial = '0;
        n_ge    = 1'b0;
        for (int c = 0; c < sapb_pkg::NUM_CHAN; c++) begin
            n_trial = {i_word.part[c], i_word.low[c][7]};
            n_ge    = (n_trial >= {1'b0, i_word.total});
            n_word.part[c] = n_ge ? 8'(n_trial - {1'b0, i_word.total}) : n_trial[7:0];
            n_word.low[c]  = {i_word.low[c][6:0], 1'b0};
            n_word.quo[c]  = {i_word.quo[c][sapb_pkg::QUO_W-2:0], n_ge};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_en) begin
            r_vld <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_word <= n_word;
        end
    end

    assign o_valid = r_vld;
    assign o_word  = r_word;

endmodule

### rtl/straight_alpha_pixel_blend.sv
`timescale 1ns / 1ps

// Straight-alpha blend of one foreground pixel over an ARGB8888 canvas pixel.
// Input channel: i_valid / o_stall with position, colour, coverage and the
// current canvas pixel. Output channel: o_valid / i_stall with write flag,
// element offset and new pixel. A word is taken on a clock edge where valid
// is high and stall is low. Canvas size, row stride and the alpha mode are
// written on the config port (i_cfg_we, i_cfg_idx, i_cfg_data); the user
// must write them only while idle, which the block does not enforce. Three
// setup stages (bounds and products, background weight, numerators) feed
// eight restoring-divider stages, one quotient bit each. All stages move
// together, one word per cycle; with a result waiting on a stalled receiver
// they hold, o_stall rises in the same cycle, nothing is dropped or repeated.
// Reset (synchronous, active low) clears the config registers to zero and
// empties the pipeline; payload registers are not reset.
// Off-canvas positions or zero coverage return the write flag clear with
// zero offset and pixel.
module straight_alpha_pixel_blend #(
    parameter int COORD_BITS = 13
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // config port
    input  logic                  i_cfg_we,
    input  logic [1:0]            i_cfg_idx,
    input  logic [COORD_BITS-1:0] i_cfg_data,
    // input channel
    input  logic                  i_valid,
    output logic                  o_stall,
    input  logic [15:0]           i_pos_x,
    input  logic [15:0]           i_pos_y,
    input  logic [23:0]           i_fore_colour,
    input  logic [7:0]            i_coverage,
    input  logic [31:0]           i_under_pixel,
    // output channel
    output logic                  o_valid,
    input  logic                  i_stall,
    output logic                  o_write_pixel,
    output logic [23:0]           o_pixel_offset,
    output logic [31:0]           o_blended_pixel
);

    localparam int DIV_STAGES = sapb_pkg::QUO_W;

    logic [COORD_BITS-1:0] w_width;
    logic [COORD_BITS-1:0] w_height;
    logic [COORD_BITS-1:0] w_stride;
    logic                  w_keeps;
    logic                  w_en;

    logic                                  w_vld  [DIV_STAGES+1];
    sapb_pkg::t_div_word                   w_word [DIV_STAGES+1];
    sapb_pkg::t_div_word                   w_last;

    // Whole pipeline advances unless a finished word is held by the receiver
    assign w_en    = !(w_vld[DIV_STAGES] && i_stall);
    assign o_stall = !w_en;

    sapb_cfg_regs #(
        .COORD_BITS (COORD_BITS)
    ) u_cfg (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_cfg_we             (i_cfg_we),
        .i_cfg_idx            (i_cfg_idx),
        .i_cfg_data           (i_cfg_data),
        .o_canvas_width       (w_width),
        .o_canvas_height      (w_height),
        .o_row_stride         (w_stride),
        .o_canvas_keeps_alpha (w_keeps)
    );

    sapb_weight #(
        .COORD_BITS (COORD_BITS)
    ) u_weight (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_en                 (w_en),
        .i_valid              (i_valid),
        .i_pos_x              (i_pos_x),
        .i_pos_y              (i_pos_y),
        .i_fore_colour        (i_fore_colour),
        .i_coverage           (i_coverage),
        .i_under_pixel        (i_under_pixel),
        .i_canvas_width       (w_width),
        .i_canvas_height      (w_height),
        .i_row_stride         (w_stride),
        .i_canvas_keeps_alpha (w_keeps),
        .o_valid              (w_vld[0]),
        .o_word               (w_word[0])
    );

    // Divider chain, most significant quotient bit first
    for (genvar s = 0; s < DIV_STAGES; s++) begin : g_div
        sapb_div_step u_step (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_valid (w_vld[s]),
            .i_word  (w_word[s]),
            .o_valid (w_vld[s+1]),
            .o_word  (w_word[s+1])
        );
    end

    // Result word; misses read as zero
    assign w_last          = w_word[DIV_STAGES];
    assign o_valid         = w_vld[DIV_STAGES];
    assign o_write_pixel   = w_last.hit;
    assign o_pixel_offset  = w_last.offset;
    assign o_blended_pixel = w_last.hit ?
                             {w_last.alpha, w_last.quo[2], w_last.quo[1], w_last.quo[0]} :
                             '0;

endmodule
